### rtl/nte_pkg.sv
// ----------------------------------------------------------------------------
// nte_pkg: shared constants and types for the NAS TAI extractor
// Protocol codes, PDU length bound and the widths derived from it.
// ----------------------------------------------------------------------------
`default_nettype none

package nte_pkg;

    // Longest PDU that is examined; longer ones report not found
    localparam int MAX_PDU_BYTES = 4096;

    // Byte counter saturates at MAX_PDU_BYTES + 1
    localparam int POS_W = $clog2(MAX_PDU_BYTES + 2);
    // Element offsets can run one TLV (up to 256 bytes) past the bound
    localparam int OFS_W = $clog2(MAX_PDU_BYTES + 257);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [OFS_W-1:0] ofs_t;

    // Protocol codes
    localparam logic [3:0] PD_EMM             = 4'h7;
    localparam logic [3:0] SEC_HDR_PLAIN      = 4'h0;
    localparam logic [7:0] TYPE_ATTACH_ACCEPT = 8'h42;
    localparam logic [7:0] TYPE_TAU_ACCEPT    = 8'h49;
    localparam logic [7:0] IEI_TAI_LIST       = 8'h54;
    localparam logic [7:0] TYPE1_MASK         = 8'hF0;
    localparam logic [7:0] TYPE1_MIN          = 8'h80;
    localparam logic [1:0] LIST_TYPE_LIMIT    = 2'h3;
    localparam logic [3:0] MNC_FILLER         = 4'hF;

    // Attach Accept layout: list length byte and first list byte
    localparam int ATTACH_LEN_POS  = 4;
    localparam int ATTACH_LIST_POS = 5;
    // First TAU element sits at body offset 1, i.e. message byte 3
    localparam int WALK_FIRST_POS  = 3;

    // Captured head of the TAI list
    localparam int LIST_CAPTURE = 6;
    localparam int CAP_IDX_W    = $clog2(LIST_CAPTURE);

    typedef logic [CAP_IDX_W-1:0] cap_idx_t;

endpackage

`default_nettype wire

### rtl/nas_tai_extractor.sv
// ----------------------------------------------------------------------------
// nas_tai_extractor: tracking area identity from an LTE NAS EMM PDU
// Parses one PDU byte per transfer and emits one result per PDU on its
// last byte: found flag, MCC, MNC and TAC of the first TAI list entry.
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata                        tuser   tlast
//  -------   ---   --------------------------   -----   ----------------
//  s_*       in    pdu_byte                     -       last PDU byte
//  m_*       out   country, network, area code  found   -
//
//  One byte is accepted per cycle unless the input stalls. After the
//  transfer of the last PDU byte the length and header checks fill the
//  finish stage, then the BCD digit arithmetic fills the output register.
//  The output register and a one-entry finish stage decouple the two sides;
//  input stalls only while a finish is held by a stalled output.
//  rst_n clears all parse state; captured list bytes need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nas_tai_extractor
    import nte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] pdu_byte
    input  wire logic        s_tlast,   // last
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [10:0] country_code, [21:11] network_code,
                                        // [37:22] area_code, [39:38] zero
    output logic             m_tuser    // found
);

    localparam pos_t POS_MAX = POS_W'(MAX_PDU_BYTES);
    localparam ofs_t OFS_MAX = OFS_W'(MAX_PDU_BYTES);

    // ------------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------------
    pos_t        byte_position_reg, byte_position_next;
    logic [7:0]  header_byte_reg,   header_byte_next;
    logic [7:0]  message_type_reg,  message_type_next;
    ofs_t        next_offset_reg,   next_offset_next;
    logic        walk_done_reg,     walk_done_next;
    logic        length_pending_reg, length_pending_next;
    ofs_t        list_start_reg,    list_start_next;
    logic [7:0]  list_length_reg,   list_length_next;
    logic        list_seen_reg,     list_seen_next;
    logic [7:0]  list_bytes_reg [LIST_CAPTURE];

    // Finish stage and output register
    logic        fin_valid_reg;
    logic        fin_ok_reg, fin_ok_next;
    logic        m_tvalid_reg;
    logic        found_reg;
    logic [10:0] country_reg;
    logic [10:0] network_reg;
    logic [15:0] area_reg;

    logic        take;
    logic        adv;
    logic [7:0]  b;
    logic [OFS_W:0] p_ext;
    logic [OFS_W:0] walk_pos;
    logic [OFS_W:0] ls_ext;
    logic [OFS_W:0] cap_offset;
    logic [OFS_W:0] list_end;
    logic        walk_hit;
    logic        cap_en;
    cap_idx_t    cap_idx;

    assign b        = s_tdata;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = !fin_valid_reg || adv;
    assign take     = s_tvalid && s_tready;

    // Position compares, all but the saturation check in one common width
    assign p_ext      = (OFS_W+1)'(byte_position_reg);
    assign walk_pos   = {1'b0, next_offset_reg} + (OFS_W+1)'(2);
    assign ls_ext     = {1'b0, list_start_reg};
    assign cap_offset = p_ext - ls_ext;
    assign walk_hit   = !walk_done_reg && (p_ext == walk_pos);
    assign cap_en     = list_seen_reg && (p_ext >= ls_ext) &&
                        (cap_offset < (OFS_W+1)'(LIST_CAPTURE)) &&
                        (byte_position_reg < POS_MAX);
    assign cap_idx    = cap_offset[CAP_IDX_W-1:0];

    // ------------------------------------------------------------------------
    // Per-byte parse: header, type, Attach length or TAU element walk
    // ------------------------------------------------------------------------
    always_comb
    begin
        byte_position_next  = byte_position_reg;
        header_byte_next    = header_byte_reg;
        message_type_next   = message_type_reg;
        next_offset_next    = next_offset_reg;
        walk_done_next      = walk_done_reg;
        length_pending_next = length_pending_reg;
        list_start_next     = list_start_reg;
        list_length_next    = list_length_reg;
        list_seen_next      = list_seen_reg;

        if (byte_position_reg < POS_MAX)
        begin
            if (byte_position_reg == pos_t'(0))
            begin
                header_byte_next = b;
            end
            else if (byte_position_reg == pos_t'(1))
            begin
                message_type_next = b;
            end
            else if (message_type_reg == TYPE_ATTACH_ACCEPT)
            begin
                if (byte_position_reg == pos_t'(ATTACH_LEN_POS))
                begin
                    list_length_next = b;
                    list_seen_next   = 1'b1;
                    list_start_next  = ofs_t'(ATTACH_LIST_POS);
                end
            end
            else if (message_type_reg == TYPE_TAU_ACCEPT &&
                     byte_position_reg >= pos_t'(WALK_FIRST_POS) && walk_hit)
            begin
                if (length_pending_reg)
                begin
                    // TLV length byte: skip the value
                    next_offset_next    = next_offset_reg + ofs_t'(b) + ofs_t'(1);
                    length_pending_next = 1'b0;
                end
                else if (list_seen_reg)
                begin
                    list_length_next = b;
                    walk_done_next   = 1'b1;
                end
                else if (b == IEI_TAI_LIST)
                begin
                    list_seen_next   = 1'b1;
                    list_start_next  = next_offset_reg + ofs_t'(4);
                    next_offset_next = next_offset_reg + ofs_t'(1);
                end
                else if ((b & TYPE1_MASK) >= TYPE1_MIN)
                begin
                    // type-1 element, one byte
                    next_offset_next = next_offset_reg + ofs_t'(1);
                end
                else
                begin
                    length_pending_next = 1'b1;
                    next_offset_next    = next_offset_reg + ofs_t'(1);
                end
                if (next_offset_next > OFS_MAX)
                begin
                    walk_done_next = 1'b1;
                end
            end
        end

        if (byte_position_reg <= POS_MAX)
        begin
            byte_position_next = byte_position_reg + pos_t'(1);
        end
    end

    // Length and header checks at the last byte; digits follow next stage
    assign list_end = {1'b0, list_start_next} + (OFS_W+1)'(list_length_next);

    always_comb
    begin
        fin_ok_next = (byte_position_next <= POS_MAX) &&
                      (byte_position_next >= pos_t'(2)) &&
                      (header_byte_next[3:0] == PD_EMM) &&
                      (header_byte_next[7:4] == SEC_HDR_PLAIN) &&
                      (message_type_next == TYPE_ATTACH_ACCEPT ||
                       message_type_next == TYPE_TAU_ACCEPT) &&
                      list_seen_next &&
                      (list_length_next >= 8'(LIST_CAPTURE)) &&
                      (list_end <= (OFS_W+1)'(byte_position_next));
    end

    // Parse state registers; cleared after every last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= '0;
            header_byte_reg    <= '0;
            message_type_reg   <= '0;
            next_offset_reg    <= ofs_t'(1);
            walk_done_reg      <= 1'b0;
            length_pending_reg <= 1'b0;
            list_start_reg     <= '0;
            list_length_reg    <= '0;
            list_seen_reg      <= 1'b0;
        end
        else if (take)
        begin
            if (s_tlast)
            begin
                byte_position_reg  <= '0;
                header_byte_reg    <= '0;
                message_type_reg   <= '0;
                next_offset_reg    <= ofs_t'(1);
                walk_done_reg      <= 1'b0;
                length_pending_reg <= 1'b0;
                list_start_reg     <= '0;
                list_length_reg    <= '0;
                list_seen_reg      <= 1'b0;
            end
            else
            begin
                byte_position_reg  <= byte_position_next;
                header_byte_reg    <= header_byte_next;
                message_type_reg   <= message_type_next;
                next_offset_reg    <= next_offset_next;
                walk_done_reg      <= walk_done_next;
                length_pending_reg <= length_pending_next;
                list_start_reg     <= list_start_next;
                list_length_reg    <= list_length_next;
                list_seen_reg      <= list_seen_next;
            end
        end
    end

    // List capture. The finish stage reads these bytes once the last byte has
    // been taken; the next PDU cannot write them before its sixth byte.
    always_ff @(posedge clk)
    begin
        if (take && cap_en)
        begin
            list_bytes_reg[cap_idx] <= b;
        end
    end

    // ------------------------------------------------------------------------
    // Finish stage
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (take && s_tlast)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s_tlast)
        begin
            fin_ok_reg <= fin_ok_next;
        end
    end

    // BCD digits to binary MCC / MNC, TAC big-endian
    logic [10:0] mcc;
    logic [10:0] mnc;
    logic [15:0] tac;
    logic        found;
    logic [3:0]  d3;

    always_comb
    begin
        d3  = list_bytes_reg[2][7:4];
        mcc = 11'(list_bytes_reg[1][3:0]) * 11'd100 +
              11'(list_bytes_reg[1][7:4]) * 11'd10 +
              11'(list_bytes_reg[2][3:0]);
        if (d3 == MNC_FILLER)
        begin
            mnc = 11'(list_bytes_reg[3][3:0]) * 11'd10 +
                  11'(list_bytes_reg[3][7:4]);
        end
        else
        begin
            mnc = 11'(list_bytes_reg[3][3:0]) * 11'd100 +
                  11'(list_bytes_reg[3][7:4]) * 11'd10 + 11'(d3);
        end
        tac   = {list_bytes_reg[4], list_bytes_reg[5]};
        found = fin_ok_reg && (list_bytes_reg[0][6:5] < LIST_TYPE_LIMIT) &&
                (mcc != 11'd0) && (tac != 16'd0);
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin_valid_reg)
        begin
            found_reg   <= found;
            country_reg <= found ? mcc : 11'd0;
            network_reg <= found ? mnc : 11'd0;
            area_reg    <= found ? tac : 16'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {2'b00, area_reg, network_reg, country_reg};

`ifndef SYNTHESIS
    // A last-byte transfer always leads to a pending finish
    a_fin_set: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> fin_valid_reg)
        else $error("finish not pending after last byte");

    // A held finish with a stalled output blocks the input
    a_fin_block: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while finish stalled");

    // A reported TAI has nonzero MCC and TAC
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[10:0] != 11'd0 && m_tdata[37:22] != 16'd0))
        else $error("found with zero MCC or TAC");

    // Not found carries all-zero codes
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 40'd0))
        else $error("not-found result with nonzero codes");

    // Byte counter never passes its saturation point
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= POS_MAX + pos_t'(1))
        else $error("byte position out of range");
`endif

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the NAS TAI extractor
// Streams EMM PDUs byte by byte into the block and compares every result
// with a cycle-free predictor of the parser. PDUs are well-formed Attach and
// TAU Accepts with random content, broken or truncated ones, noise, and a few
// at and past the length bound. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

// One expected result: found flag and the three identity codes
typedef struct packed {
    logic        found;
    logic [10:0] country_code;
    logic [10:0] network_code;
    logic [15:0] area_code;
} tai_t;

class tai_scoreboard_t;

    // parse state of the PDU in progress
    nte_pkg::pos_t byte_cnt;
    logic [7:0]    hdr;
    logic [7:0]    mtype_byte;
    nte_pkg::ofs_t elem_ofs;
    bit            walk_end;
    nte_pkg::ofs_t list_pos;
    logic [7:0]    list_len;
    bit            list_hit;
    bit            len_next;
    logic [7:0]    cap [nte_pkg::LIST_CAPTURE];

    tai_t tai_expected[$];
    int   errors;
    int   n_results;
    int   n_found;

    function new();
        errors    = 0;
        n_results = 0;
        n_found   = 0;
        clear_pdu();
    endfunction

    function void clear_pdu();
        byte_cnt   = '0;
        hdr        = '0;
        mtype_byte = '0;
        elem_ofs   = nte_pkg::ofs_t'(1);
        walk_end   = 1'b0;
        list_pos   = '0;
        list_len   = '0;
        list_hit   = 1'b0;
        len_next   = 1'b0;
        foreach (cap[i]) cap[i] = '0;
    endfunction

    // TAU Accept: step through type-1 and TLV elements until the TAI list
    function void walk_elements(int p, logic [7:0] b);
        if (walk_end || p != int'(elem_ofs) + 2)
            return;
        if (len_next)
        begin
            elem_ofs = nte_pkg::ofs_t'(int'(elem_ofs) + 1 + int'(b));
            len_next = 1'b0;
        end
        else if (list_hit)
        begin
            list_len = b;
            walk_end = 1'b1;
        end
        else if (b == nte_pkg::IEI_TAI_LIST)
        begin
            list_hit = 1'b1;
            list_pos = nte_pkg::ofs_t'(int'(elem_ofs) + 4);
            elem_ofs = nte_pkg::ofs_t'(int'(elem_ofs) + 1);
        end
        else if ((b & nte_pkg::TYPE1_MASK) >= nte_pkg::TYPE1_MIN)
        begin
            elem_ofs = nte_pkg::ofs_t'(int'(elem_ofs) + 1);
        end
        else
        begin
            len_next = 1'b1;
            elem_ofs = nte_pkg::ofs_t'(int'(elem_ofs) + 1);
        end
        if (int'(elem_ofs) > nte_pkg::MAX_PDU_BYTES)
            walk_end = 1'b1;
    endfunction

    function void parse_byte(int p, logic [7:0] b);
        if (p == 0)
            hdr = b;
        else if (p == 1)
            mtype_byte = b;
        else if (mtype_byte == nte_pkg::TYPE_ATTACH_ACCEPT)
        begin
            if (p == nte_pkg::ATTACH_LEN_POS)
            begin
                list_len = b;
                list_hit = 1'b1;
                list_pos = nte_pkg::ofs_t'(nte_pkg::ATTACH_LIST_POS);
            end
        end
        else if (mtype_byte == nte_pkg::TYPE_TAU_ACCEPT && p >= nte_pkg::WALK_FIRST_POS)
            walk_elements(p, b);
        // capture the head of the list
        if (list_hit && p >= int'(list_pos) && p < int'(list_pos) + nte_pkg::LIST_CAPTURE)
            cap[p - int'(list_pos)] = b;
    endfunction

    // Length and content checks at the end of the PDU, then BCD decode
    function tai_t decode_tai(int total);
        tai_t       r;
        int         mcc;
        int         mnc;
        int         tac;
        logic [3:0] d3;
        r = '0;
        if (total > nte_pkg::MAX_PDU_BYTES || total < 2)
            return r;
        if (hdr[3:0] != nte_pkg::PD_EMM || hdr[7:4] != nte_pkg::SEC_HDR_PLAIN)
            return r;
        if (mtype_byte != nte_pkg::TYPE_ATTACH_ACCEPT &&
            mtype_byte != nte_pkg::TYPE_TAU_ACCEPT)
            return r;
        if (!list_hit || list_len < nte_pkg::LIST_CAPTURE ||
            int'(list_pos) + int'(list_len) > total)
            return r;
        if (cap[0][6:5] >= nte_pkg::LIST_TYPE_LIMIT)
            return r;
        mcc = cap[1][3:0] * 100 + cap[1][7:4] * 10 + cap[2][3:0];
        d3  = cap[2][7:4];
        if (d3 == nte_pkg::MNC_FILLER)
            mnc = cap[3][3:0] * 10 + cap[3][7:4];
        else
            mnc = cap[3][3:0] * 100 + cap[3][7:4] * 10 + d3;
        tac = {cap[4], cap[5]};
        if (mcc == 0 || tac == 0)
            return r;
        r.found        = 1'b1;
        r.country_code = mcc[10:0];
        r.network_code = mnc[10:0];
        r.area_code    = tac[15:0];
        return r;
    endfunction

    // Accepted input transfer
    function void note_byte(logic [7:0] b, logic is_last);
        int p;
        p = int'(byte_cnt);
        if (p < nte_pkg::MAX_PDU_BYTES)
            parse_byte(p, b);
        if (p <= nte_pkg::MAX_PDU_BYTES)
            byte_cnt = nte_pkg::pos_t'(p + 1);
        if (is_last)
        begin
            tai_expected.push_back(decode_tai(int'(byte_cnt)));
            clear_pdu();
        end
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Accepted output transfer
    function void check_result(logic found, logic [39:0] d);
        tai_t want;
        if (tai_expected.size() == 0)
        begin
            errors++;
            $display("%0t: result with none expected: expected none, actual found=%0d data=%h",
                     $time, found, d);
            return;
        end
        want = tai_expected.pop_front();
        n_results++;
        if (want.found)
            n_found++;
        compare_field("found", want.found, found);
        compare_field("country_code", want.country_code, d[10:0]);
        compare_field("network_code", want.network_code, d[21:11]);
        compare_field("area_code", want.area_code, d[37:22]);
        compare_field("pad", 0, d[39:38]);
    endfunction

    function int outstanding();
        return tai_expected.size();
    endfunction

endclass

module tb_top
    import nte_pkg::*;
();

    // non-TAI codes used to build stimulus
    localparam logic [7:0] TYPE_ATTACH_REJECT = 8'h44;
    localparam logic [7:0] IEI_OTHER_TLV      = 8'h30;
    localparam logic [3:0] PD_OTHER           = 4'h2;
    localparam logic [3:0] SEC_HDR_INTEGRITY  = 4'h1;
    localparam int         HOLD_CYCLES        = 300;

    typedef enum {RX_OPEN, RX_COIN, RX_EVERY4, RX_MOSTLY} rx_mode_t;
    typedef enum {CUT_TAIL, BAD_HEADER, SEC_HEADER, BAD_TYPE, SCRAMBLE} flaw_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    tai_scoreboard_t sb;

    logic [7:0] pdu_q[$];
    logic [7:0] head [LIST_CAPTURE];
    int         burst_left;
    bit         steady;
    bit         hold_start;
    int         byte_count;
    int         pdu_count;
    int         in_stalls;

    nas_tai_extractor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Monitor both channels on every edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (s_tvalid && !s_tready)
                in_stalls++;
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(64, 256);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_EVERY4: m_tready <= (phase % 4 == 0);
                    default:   m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // One byte, with bursty gaps ahead of it
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (!steady && $urandom_range(0, 1) == 1)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        byte_count++;
    endtask

    task automatic send_pdu();
        int n;
        n = pdu_q.size();
        for (int i = 0; i < n; i++)
            send_byte(pdu_q[i], i == n - 1);
        pdu_q.delete();
        pdu_count++;
    endtask

    // Stop offering until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    task automatic push_rand(input int n);
        repeat (n) pdu_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic set_head(input logic [7:0] h0, h1, h2, h3, h4, h5);
        head[0] = h0;
        head[1] = h1;
        head[2] = h2;
        head[3] = h3;
        head[4] = h4;
        head[5] = h5;
    endtask

    // mostly decimal digits, now and then a nibble above nine
    function automatic logic [3:0] bcd_digit();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(10, 15));
        return 4'($urandom_range(0, 9));
    endfunction

    // Random first list entry; list type 3 only when any_type is set
    task automatic rand_head(input bit any_type);
        logic [1:0] ltype;
        ltype   = 2'($urandom_range(0, any_type ? 3 : 2));
        head[0] = 8'($urandom_range(0, 255));
        head[0][6:5] = ltype;
        head[1] = {bcd_digit(), bcd_digit()};
        head[2] = {($urandom_range(0, 1) == 1) ? MNC_FILLER : bcd_digit(), bcd_digit()};
        head[3] = {bcd_digit(), bcd_digit()};
        head[4] = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        head[5] = 8'($urandom_range(0, 255));
    endtask

    task automatic put_list(input int len);
        for (int i = 0; i < LIST_CAPTURE; i++)
            pdu_q.push_back(head[i]);
        if (len > LIST_CAPTURE)
            push_rand(len - LIST_CAPTURE);
    endtask

    task automatic put_attach(input int len, input int extra);
        pdu_q.push_back({SEC_HDR_PLAIN, PD_EMM});
        pdu_q.push_back(TYPE_ATTACH_ACCEPT);
        push_rand(2);
        pdu_q.push_back(8'(len));
        put_list(len);
        push_rand(extra);
    endtask

    // Random type-1 and TLV elements, never the TAI list IEI
    task automatic put_elements(input int n, input int max_len);
        logic [7:0] iei;
        int         len;
        repeat (n)
        begin
            if ($urandom_range(0, 2) == 0)
                pdu_q.push_back(8'($urandom_range(TYPE1_MIN, 255)));
            else
            begin
                iei = 8'($urandom_range(0, TYPE1_MIN - 1));
                if (iei == IEI_TAI_LIST)
                    iei = iei + 8'd1;
                len = $urandom_range(0, max_len);
                pdu_q.push_back(iei);
                pdu_q.push_back(8'(len));
                push_rand(len);
            end
        end
    endtask

    task automatic put_tau(input int pre, input int post, input bit with_list,
                           input int len, input int max_len);
        pdu_q.push_back({SEC_HDR_PLAIN, PD_EMM});
        pdu_q.push_back(TYPE_TAU_ACCEPT);
        push_rand(1);
        put_elements(pre, max_len);
        if (with_list)
        begin
            pdu_q.push_back(IEI_TAI_LIST);
            pdu_q.push_back(8'(len));
            put_list(len);
        end
        put_elements(post, max_len);
    endtask

    task automatic put_good();
        rand_head(1'b0);
        if ($urandom_range(0, 1) == 1)
            put_attach($urandom_range(6, 12), $urandom_range(0, 4));
        else
            put_tau($urandom_range(0, 4), $urandom_range(0, 2), 1'b1,
                    $urandom_range(6, 12), 8);
    endtask

    task automatic put_broken();
        flaw_t flaw;
        put_good();
        flaw = flaw_t'($urandom_range(0, 4));
        case (flaw)
            CUT_TAIL:   repeat ($urandom_range(1, pdu_q.size() - 1)) void'(pdu_q.pop_back());
            BAD_HEADER: pdu_q[0] = 8'($urandom_range(0, 255));
            SEC_HEADER: pdu_q[0][7:4] = 4'($urandom_range(1, 15));
            BAD_TYPE:   pdu_q[1] = 8'($urandom_range(0, 255));
            default:    pdu_q[$urandom_range(2, pdu_q.size() - 1)] = 8'($urandom_range(0, 255));
        endcase
    endtask

    task automatic put_noise();
        push_rand($urandom_range(1, 16));
        if (pdu_q.size() > 1 && $urandom_range(0, 2) == 0)
        begin
            pdu_q[0] = {SEC_HDR_PLAIN, PD_EMM};
            pdu_q[1] = ($urandom_range(0, 1) == 1) ? TYPE_ATTACH_ACCEPT : TYPE_TAU_ACCEPT;
        end
    endtask

    // Stimulus
    initial
    begin
        int r;
        int rnd_bytes;
        int rnd_pdus;
        sb         = new();
        burst_left = 0;
        steady     = 1'b0;
        hold_start = 1'b0;
        byte_count = 0;
        pdu_count  = 0;
        in_stalls  = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two-digit MNC, list ends on the last byte
        set_head(8'h00, 8'h21, 8'hF3, 8'h54, 8'h12, 8'h34);
        put_attach(6, 0);
        send_pdu();
        // three-digit MNC, longer list and trailing bytes
        set_head(8'h20, 8'h13, 8'h02, 8'h01, 8'hFF, 8'hFF);
        put_attach(9, 2);
        send_pdu();
        // all MCC and MNC digit nibbles above nine
        set_head(8'h40, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01);
        put_attach(6, 0);
        send_pdu();
        // list type 3
        set_head(8'h60, 8'h21, 8'hF3, 8'h54, 8'h12, 8'h34);
        put_attach(6, 0);
        send_pdu();
        // zero MCC, then zero TAC
        set_head(8'h00, 8'h00, 8'hF0, 8'h10, 8'h00, 8'h01);
        put_attach(6, 0);
        send_pdu();
        set_head(8'h00, 8'h21, 8'hF3, 8'h54, 8'h00, 8'h00);
        put_attach(6, 0);
        send_pdu();

        set_head(8'h00, 8'h62, 8'hF2, 8'h10, 8'hAB, 8'hCD);
        // list length below six
        put_attach(5, 0);
        send_pdu();
        // list runs past the end of the PDU
        put_attach(12, 0);
        repeat (3) void'(pdu_q.pop_back());
        send_pdu();
        // nonzero security header, wrong discriminator, other message type
        put_attach(6, 0);
        pdu_q[0] = {SEC_HDR_INTEGRITY, PD_EMM};
        send_pdu();
        put_attach(6, 0);
        pdu_q[0] = {SEC_HDR_PLAIN, PD_OTHER};
        send_pdu();
        put_attach(6, 0);
        pdu_q[1] = TYPE_ATTACH_REJECT;
        send_pdu();
        // one-byte and two-byte PDUs
        pdu_q.push_back({SEC_HDR_PLAIN, PD_EMM});
        send_pdu();
        pdu_q.push_back({SEC_HDR_PLAIN, PD_EMM});
        pdu_q.push_back(TYPE_ATTACH_ACCEPT);
        send_pdu();
        // TAU with the list as first element
        put_tau(0, 0, 1'b1, 6, 0);
        send_pdu();
        // TAU: type-1 element, TLV hiding the list IEI in its payload, then list
        pdu_q.push_back({SEC_HDR_PLAIN, PD_EMM});
        pdu_q.push_back(TYPE_TAU_ACCEPT);
        pdu_q.push_back(8'h00);
        pdu_q.push_back(TYPE1_MIN + 8'h0B);
        pdu_q.push_back(IEI_OTHER_TLV);
        pdu_q.push_back(8'h02);
        pdu_q.push_back(IEI_TAI_LIST);
        pdu_q.push_back(IEI_TAI_LIST);
        pdu_q.push_back(IEI_TAI_LIST);
        pdu_q.push_back(8'h06);
        put_list(6);
        send_pdu();
        // TAU without list, and with a truncated list
        put_tau(3, 2, 1'b0, 0, 4);
        send_pdu();
        put_tau(1, 0, 1'b1, 10, 4);
        repeat (4) void'(pdu_q.pop_back());
        send_pdu();

        // PDUs at and past the length bound
        steady = 1'b1;
        set_head(8'h00, 8'h44, 8'hF0, 8'h10, 8'h00, 8'h07);
        put_attach(6, 0);
        push_rand(MAX_PDU_BYTES - pdu_q.size());
        send_pdu();
        put_attach(6, 0);
        push_rand(MAX_PDU_BYTES + 1 - pdu_q.size());
        send_pdu();
        // TAU list behind fifteen maximal TLVs
        pdu_q.push_back({SEC_HDR_PLAIN, PD_EMM});
        pdu_q.push_back(TYPE_TAU_ACCEPT);
        push_rand(1);
        repeat (15)
        begin
            pdu_q.push_back(IEI_OTHER_TLV);
            pdu_q.push_back(8'hFF);
            push_rand(255);
        end
        pdu_q.push_back(IEI_TAI_LIST);
        pdu_q.push_back(8'h06);
        put_list(6);
        push_rand(MAX_PDU_BYTES - pdu_q.size());
        send_pdu();
        steady = 1'b0;

        // Random PDUs: mostly well-formed, some broken, some noise
        rnd_bytes = byte_count;
        rnd_pdus  = 0;
        while (byte_count - rnd_bytes < 750 || rnd_pdus < 60)
        begin
            if (rnd_pdus % 10 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (rnd_pdus == 25)
            begin
                // output held off while input keeps coming
                drain();
                steady     = 1'b1;
                hold_start = 1'b1;
                repeat (12)
                begin
                    rand_head(1'b0);
                    put_attach(6, 0);
                    send_pdu();
                end
                drain();
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                put_good();
            else if (r < 88)
                put_broken();
            else
                put_noise();
            send_pdu();
            rnd_pdus++;
        end

        drain();
        repeat (16) @(posedge clk);
        $display("Summary: %0d PDUs, %0d bytes incl. PDUs at and past the length bound",
                 pdu_count, byte_count);
        $display("Summary: %0d results checked, %0d with a TAI, %0d input stall cycles",
                 sb.n_results, sb.n_found, in_stalls);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
